[rtl/core/subblock_heat_replacement_core_defines.svh]
// Assertion macros for the subblock heat replacement core checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef SUBBLOCK_HEAT_REPLACEMENT_CORE_DEFINES_SVH
`define SUBBLOCK_HEAT_REPLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SHR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/shr_pkg.sv]
// Shared types, constants and helpers for the subblock heat replacement core.
// No dependencies.
package shr_pkg;

    localparam int WAYS   = 8;
    localparam int SUBS   = 4;
    localparam int SLOTS  = WAYS * SUBS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W = WAY_W + 2;

    // operation codes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_VICTIM = 2'd1;
    localparam logic [1:0] MODE_HEAT   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_THR_ONE   = 3'd0;
    localparam logic [2:0] CFG_THR_TWO   = 3'd1;
    localparam logic [2:0] CFG_THR_THREE = 3'd2;
    localparam logic [2:0] CFG_THR_FOUR  = 3'd3;

    localparam logic [31:0] THR_ONE_RST   = 32'd10000;
    localparam logic [31:0] THR_TWO_RST   = 32'd20000;
    localparam logic [31:0] THR_THREE_RST = 32'd30000;
    localparam logic [31:0] THR_FOUR_RST  = 32'd40000;

    // heat levels, hottest first
    localparam logic [7:0] HEAT_L0 = 8'h87;
    localparam logic [7:0] HEAT_L1 = 8'h69;
    localparam logic [7:0] HEAT_L2 = 8'h5f;
    localparam logic [7:0] HEAT_L3 = 8'h5a;
    localparam logic [7:0] HEAT_L4 = 8'h55;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       wtime;
        logic [7:0]        heat;
    } t_slot_wr;

    // place mask bits 3..0 at request bits 12, 8, 4, 0
    function automatic logic [15:0] spread_mask(input logic [3:0] m);
        logic [15:0] s;
        s     = '0;
        s[12] = m[3];
        s[8]  = m[2];
        s[4]  = m[1];
        s[0]  = m[0];
        return s;
    endfunction

endpackage

[rtl/core/subblock_heat_replacement_core.sv]
// Subblock heat replacement core: replacement state for one cache set.
// Steps from accept to result: write touch does gap subtract, four threshold compares,
// update, result register; victim choice scans one way per cycle, then finish, result
// register; heat read and unused mode do finish, result register. Busy drops as o_done
// strobes, so the next one goes in then, not before. The receiver cannot stall results.
// Synchronous active-low reset clears masks and slot valid bits and reloads the thresholds.
module subblock_heat_replacement_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_way_index,
    input  logic [5:0]  i_byte_offset,
    input  logic [31:0] i_now_tick,
    input  logic [15:0] i_request_type,
    input  logic [1:0]  i_query_subblock,
    output logic        o_done,
    output logic [2:0]  o_victim_way,
    output logic [7:0]  o_heat_value,
    output logic [3:0]  o_way_written_mask
);

    // sequencer state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GAP  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int WW = shr_pkg::WAY_W;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [WW-1:0] r_way, n_way;
    logic          r_way_ok, n_way_ok;
    logic [1:0]    r_sub, n_sub;
    logic [31:0]   r_now, n_now;
    logic [15:0]   r_req, n_req;
    logic [31:0]   r_gap, n_gap;
    logic [1:0]    r_k, n_k;
    logic [3:0]    r_le, n_le;
    logic [WW-1:0] r_scan, n_scan;
    logic [WW-1:0] r_victim, n_victim;
    logic [3:0]    r_mask [shr_pkg::WAYS];
    logic [3:0]    n_mask [shr_pkg::WAYS];
    logic [31:0]   r_thr [4];
    logic [31:0]   n_thr [4];
    logic          r_done, n_done;
    logic [2:0]    r_victim_out, n_victim_out;
    logic [7:0]    r_heat_out, n_heat_out;
    logic [3:0]    r_mask_out, n_mask_out;

    logic                       accept;
    logic [shr_pkg::SLOT_W-1:0] rd_addr;
    logic [31:0]                rd_time;
    logic [7:0]                 rd_heat;
    shr_pkg::t_slot_wr          slot_wr;
    logic                       cmp_le;
    logic [7:0]                 new_heat;
    logic [3:0]                 upd_mask;
    logic                       scan_hit;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // address the slot store straight from the inputs so its read lands at accept
    assign rd_addr = {WW'(i_way_index),
                      (i_mode == shr_pkg::MODE_HEAT) ? i_query_subblock : i_byte_offset[5:4]};

    shr_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_time (rd_time),
        .o_rd_heat (rd_heat),
        .i_wr      (slot_wr)
    );

    // shared compare unit: one threshold per cycle
    assign cmp_le = (r_gap <= r_thr[r_k]);

    // bins tested in order, the last match wins; one always matches
    always_comb begin
        new_heat = shr_pkg::HEAT_L4;
        if (r_le[0]) begin
            new_heat = shr_pkg::HEAT_L0;
        end
        if (!r_le[0] && r_le[1]) begin
            new_heat = shr_pkg::HEAT_L1;
        end
        if (!r_le[1] && r_le[2]) begin
            new_heat = shr_pkg::HEAT_L2;
        end
        if (!r_le[2] && r_le[3]) begin
            new_heat = shr_pkg::HEAT_L3;
        end
        if (!r_le[3]) begin
            new_heat = shr_pkg::HEAT_L4;
        end
    end

    // bit 3 stands for subblock 0
    assign upd_mask = r_mask[r_way] | (4'b1000 >> r_sub);
    assign scan_hit = ((r_req & shr_pkg::spread_mask(r_mask[r_scan])) == 16'd0);

    always_comb begin
        slot_wr.en    = (r_state == S_UPD);
        slot_wr.addr  = {r_way, r_sub};
        slot_wr.wtime = r_now;
        slot_wr.heat  = new_heat;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_way        = r_way;
        n_way_ok     = r_way_ok;
        n_sub        = r_sub;
        n_now        = r_now;
        n_req        = r_req;
        n_gap        = r_gap;
        n_k          = r_k;
        n_le         = r_le;
        n_scan       = r_scan;
        n_victim     = r_victim;
        n_mask       = r_mask;
        n_thr        = r_thr;
        n_done       = 1'b0;
        n_victim_out = r_victim_out;
        n_heat_out   = r_heat_out;
        n_mask_out   = r_mask_out;

        // user writes configuration only while idle, not enforced; ignore unknown indexes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                shr_pkg::CFG_THR_ONE:   n_thr[0] = i_cfg_wdata;
                shr_pkg::CFG_THR_TWO:   n_thr[1] = i_cfg_wdata;
                shr_pkg::CFG_THR_THREE: n_thr[2] = i_cfg_wdata;
                shr_pkg::CFG_THR_FOUR:  n_thr[3] = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode   = i_mode;
                    n_way    = WW'(i_way_index);
                    n_way_ok = (32'(i_way_index) < 32'(shr_pkg::WAYS));
                    n_sub    = i_byte_offset[5:4];
                    n_now    = i_now_tick;
                    n_req    = i_request_type;
                    n_scan   = '0;
                    n_victim = '0;
                    if (i_mode == shr_pkg::MODE_WRITE && n_way_ok) begin
                        n_state = S_GAP;
                    end else if (i_mode == shr_pkg::MODE_VICTIM) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_GAP: begin
                // wrapping gap since the slot's last write
                n_gap   = r_now - rd_time;
                n_k     = 2'd0;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_le[r_k] = cmp_le;
                n_k       = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_mask[r_way] = upd_mask;
                n_done        = 1'b1;
                n_victim_out  = 3'd0;
                n_heat_out    = new_heat;
                n_mask_out    = upd_mask;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                // keep the last qualifying way
                if (scan_hit) begin
                    n_victim = r_scan;
                end
                if (r_scan == WW'(shr_pkg::WAYS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_scan = r_scan + WW'(1);
                end
            end
            S_FIN: begin
                n_done       = 1'b1;
                n_victim_out = (r_mode == shr_pkg::MODE_VICTIM) ? 3'(r_victim) : 3'd0;
                n_heat_out   = (r_mode == shr_pkg::MODE_HEAT && r_way_ok) ? rd_heat : 8'd0;
                n_mask_out   = r_way_ok ? r_mask[r_way] : 4'd0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_thr   <= '{shr_pkg::THR_ONE_RST, shr_pkg::THR_TWO_RST,
                         shr_pkg::THR_THREE_RST, shr_pkg::THR_FOUR_RST};
            for (int i = 0; i < shr_pkg::WAYS; i++) begin
                r_mask[i] <= 4'd0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_thr   <= n_thr;
            r_mask  <= n_mask;
        end
    end

    // payload: hold the transaction and the result, no reset needed
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_way        <= n_way;
        r_way_ok     <= n_way_ok;
        r_sub        <= n_sub;
        r_now        <= n_now;
        r_req        <= n_req;
        r_gap        <= n_gap;
        r_k          <= n_k;
        r_le         <= n_le;
        r_scan       <= n_scan;
        r_victim     <= n_victim;
        r_victim_out <= n_victim_out;
        r_heat_out   <= n_heat_out;
        r_mask_out   <= n_mask_out;
    end

    assign o_done             = r_done;
    assign o_victim_way       = r_victim_out;
    assign o_heat_value       = r_heat_out;
    assign o_way_written_mask = r_mask_out;

endmodule

[rtl/core/shr_slot_store.sv]
// Per-subblock store: last write time and heat level, with per-slot valid bits.
// Depends on shr_pkg.
module shr_slot_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [shr_pkg::SLOT_W-1:0] i_rd_addr,
    output logic [31:0]                o_rd_time,
    output logic [7:0]                 o_rd_heat,
    input  shr_pkg::t_slot_wr          i_wr
);

    logic [31:0]              mem_time [shr_pkg::SLOTS];
    logic [7:0]               mem_heat [shr_pkg::SLOTS];
    logic [shr_pkg::SLOTS-1:0] r_valid;
    logic [31:0]              r_rd_time;
    logic [7:0]               r_rd_heat;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_time[i_wr.addr] <= i_wr.wtime;
            mem_heat[i_wr.addr] <= i_wr.heat;
        end
        r_rd_time <= mem_time[i_rd_addr];
        r_rd_heat <= mem_heat[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // a slot never written reads as its reset value, zero
    assign o_rd_time = r_rd_valid ? r_rd_time : 32'd0;
    assign o_rd_heat = r_rd_valid ? r_rd_heat : 8'd0;

endmodule

[rtl/core/shr_checker.sv]
// Port-level checker for the subblock heat replacement core, bound to the top.
// Depends on subblock_heat_replacement_core_defines.svh.
`include "subblock_heat_replacement_core_defines.svh"

module shr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // an accepted transaction makes the block busy
    `SHR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
    // a result closes the transaction and frees the block
    `SHR_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while busy")
    // a result follows only a busy period
    `SHR_ASSERT_NOW(a_done_after_busy, o_done, $past(busy), "result without a transaction")
    // busy rises only after an accepted start
    `SHR_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose without start")

endmodule

bind subblock_heat_replacement_core shr_checker u_shr_checker (.*);

[verif/heat_replacement_check_pkg.sv]
// Transaction types and the scoreboard for the subblock heat replacement core bench.
// Depends on shr_pkg for the way count, operation codes, register indexes and heat levels.
package heat_replacement_check_pkg;

    import shr_pkg::*;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  way;
        logic [5:0]  offset;
        logic [31:0] now_tick;
        logic [15:0] req_type;
        logic [1:0]  qsub;
    } set_request_t;

    typedef struct packed {
        logic [2:0] victim;
        logic [7:0] heat;
        logic [3:0] mask;
    } set_outcome_t;

    class set_state_scoreboard;
        logic [31:0]  thresholds[4];
        logic [3:0]   way_mask[WAYS];
        logic [31:0]  write_stamp[SLOTS];
        logic [7:0]   slot_heat[SLOTS];
        set_outcome_t awaited[$];
        int unsigned  mismatches;
        int unsigned  mode_seen[4];

        function new();
            thresholds[0] = THR_ONE_RST;
            thresholds[1] = THR_TWO_RST;
            thresholds[2] = THR_THREE_RST;
            thresholds[3] = THR_FOUR_RST;
            foreach (way_mask[w]) way_mask[w] = '0;
            foreach (write_stamp[s]) begin
                write_stamp[s] = '0;
                slot_heat[s]   = '0;
            end
            mismatches = 0;
            foreach (mode_seen[m]) mode_seen[m] = 0;
        endfunction

        // unmapped indexes fall through and change nothing
        function void set_threshold(logic [2:0] idx, logic [31:0] value);
            case (idx)
                CFG_THR_ONE:   thresholds[0] = value;
                CFG_THR_TWO:   thresholds[1] = value;
                CFG_THR_THREE: thresholds[2] = value;
                CFG_THR_FOUR:  thresholds[3] = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] widen_mask(logic [3:0] m);
            logic [15:0] r;
            r = '0;
            for (int k = 0; k < 4; k++) r[4*k] = m[k];
            return r;
        endfunction

        // every bin is tested; the last one that matches wins
        function logic [7:0] grade_gap(logic [31:0] gap, logic [7:0] prior);
            logic [7:0] h;
            h = prior;
            if (gap <= thresholds[0]) h = HEAT_L0;
            if (gap > thresholds[0] && gap <= thresholds[1]) h = HEAT_L1;
            if (gap > thresholds[1] && gap <= thresholds[2]) h = HEAT_L2;
            if (gap > thresholds[2] && gap <= thresholds[3]) h = HEAT_L3;
            if (gap > thresholds[3]) h = HEAT_L4;
            return h;
        endfunction

        function set_outcome_t predict(set_request_t r);
            set_outcome_t o;
            int           slot;
            logic [31:0]  gap;
            bit           way_ok;
            o      = '0;
            way_ok = int'(r.way) < WAYS;
            case (r.mode)
                MODE_WRITE: begin
                    if (way_ok) begin
                        slot = int'(r.way) * SUBS + int'(r.offset[5:4]);
                        gap  = r.now_tick - write_stamp[slot];
                        way_mask[r.way][3 - int'(r.offset[5:4])] = 1'b1;
                        slot_heat[slot]   = grade_gap(gap, slot_heat[slot]);
                        write_stamp[slot] = r.now_tick;
                        o.heat            = slot_heat[slot];
                    end
                end
                MODE_VICTIM: begin
                    for (int w = 0; w < WAYS; w++)
                        if ((r.req_type & widen_mask(way_mask[w])) == '0) o.victim = 3'(w);
                end
                MODE_HEAT: begin
                    if (way_ok) o.heat = slot_heat[int'(r.way) * SUBS + int'(r.qsub)];
                end
                default: ;
            endcase
            o.mask = way_ok ? way_mask[r.way] : 4'd0;
            return o;
        endfunction

        function void note_request(set_request_t r);
            awaited.push_back(predict(r));
            mode_seen[r.mode]++;
        endfunction

        function void check_response(set_outcome_t got);
            set_outcome_t want;
            if (awaited.size() == 0) begin
                $error("result with no transaction outstanding: victim %0d heat 0x%02h mask 0x%0h",
                       got.victim, got.heat, got.mask);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.victim !== want.victim) begin
                $error("victim_way: expected %0d, got %0d", want.victim, got.victim);
                mismatches++;
            end
            if (got.heat !== want.heat) begin
                $error("heat_value: expected 0x%02h, got 0x%02h", want.heat, got.heat);
                mismatches++;
            end
            if (got.mask !== want.mask) begin
                $error("way_written_mask: expected 0x%0h, got 0x%0h", want.mask, got.mask);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

[verif/tb.sv]
// Self-checking bench for subblock_heat_replacement_core: directed corner cases, then
// randomized phases under several threshold settings. Depends on shr_pkg and
// heat_replacement_check_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shr_pkg::*;
    import heat_replacement_check_pkg::*;

    // the fourth operation code is unused by the block but legal on the port
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE_TICKS = 20;
    localparam int         PHASE_ITEMS  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic [1:0]  i_mode;
    logic [2:0]  i_way_index;
    logic [5:0]  i_byte_offset;
    logic [31:0] i_now_tick;
    logic [15:0] i_request_type;
    logic [1:0]  i_query_subblock;
    logic        o_done;
    logic [2:0]  o_victim_way;
    logic [7:0]  o_heat_value;
    logic [3:0]  o_way_written_mask;

    set_state_scoreboard board = new();

    int unsigned cycle_count = 0;
    int unsigned settings_run = 0;
    logic [31:0] tick_now = '0;    // running time base for write touches
    logic [31:0] tick_span = 32'd1000;
    int          open_ways = WAYS - 1; // the last way stays lightly written until the last phase
    int          burst_left = 0;

    subblock_heat_replacement_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_mode             (i_mode),
        .i_way_index        (i_way_index),
        .i_byte_offset      (i_byte_offset),
        .i_now_tick         (i_now_tick),
        .i_request_type     (i_request_type),
        .i_query_subblock   (i_query_subblock),
        .o_done             (o_done),
        .o_victim_way       (o_victim_way),
        .o_heat_value       (o_heat_value),
        .o_way_written_mask (o_way_written_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check every strobed result against the oldest prediction; values are the ones
    // present just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_response({o_victim_way, o_heat_value, o_way_written_mask});
    end

    // Bound the run; a hung handshake lands here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, board.outstanding());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one transaction at the falling edge and hold it until a rising edge sees
    // start high with busy low; the prediction is taken at that edge.
    task automatic issue(input set_request_t r);
        @(negedge i_clk);
        i_mode           <= r.mode;
        i_way_index      <= r.way;
        i_byte_offset    <= r.offset;
        i_now_tick       <= r.now_tick;
        i_request_type   <= r.req_type;
        i_query_subblock <= r.qsub;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
    endtask

    // Drop start and hold it low for a number of cycles (at least one).
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop start and wait until every predicted result has come back and the core is idle.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.outstanding() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_threshold(idx, value);
    endtask

    task automatic set_thresholds(input logic [31:0] t1, input logic [31:0] t2,
                                  input logic [31:0] t3, input logic [31:0] t4);
        write_reg(CFG_THR_ONE, t1);
        write_reg(CFG_THR_TWO, t2);
        write_reg(CFG_THR_THREE, t3);
        write_reg(CFG_THR_FOUR, t4);
        settings_run++;
    endtask

    task automatic directed(input logic [1:0] mode, input logic [2:0] way,
                            input logic [5:0] offset, input logic [31:0] now_tick,
                            input logic [15:0] req_type, input logic [1:0] qsub);
        set_request_t r;
        r = '{mode, way, offset, now_tick, req_type, qsub};
        issue(r);
    endtask

    // Build one random transaction. Request types are mostly sparse in the subblock bits
    // so that victim choice stays interesting once most masks have filled up.
    function automatic set_request_t random_request();
        set_request_t r;
        int           pick;
        int           k;
        r.mode   = 2'($urandom_range(0, 19) < 9 ? MODE_WRITE : 0);
        pick     = $urandom_range(0, 19);
        if (pick < 9)       r.mode = MODE_WRITE;
        else if (pick < 15) r.mode = MODE_VICTIM;
        else if (pick < 19) r.mode = MODE_HEAT;
        else                r.mode = MODE_UNUSED;
        r.way    = 3'($urandom_range(0, WAYS - 1));
        r.offset = 6'($urandom_range(0, 63));
        r.qsub   = 2'($urandom_range(0, 3));
        if (r.mode == MODE_WRITE) begin
            // keep the upper ways partially written so their masks stay mixed
            r.way = 3'($urandom_range(0, open_ways - 1));
            if (int'(r.way) == WAYS - 2) r.offset[5] = 1'b0;
        end
        // advance time; now and then jump anywhere, which also moves time backwards
        if ($urandom_range(0, 19) == 0) tick_now = $urandom;
        else                            tick_now = tick_now + $urandom_range(0, tick_span);
        r.now_tick = tick_now;
        case ($urandom_range(0, 3))
            0: r.req_type = 16'($urandom);
            1: r.req_type = '0;
            default: begin
                k          = $urandom_range(0, 4);
                r.req_type = 16'($urandom) & ~16'h1111;
                if (k < 4) r.req_type = r.req_type | (16'h1 << (4 * k));
            end
        endcase
        return r;
    endfunction

    // Random traffic in bursts, gapped if idle_on; occasionally let everything drain.
    task automatic run_phase(input int count, input bit idle_on);
        for (int n = 0; n < count; n++) begin
            issue(random_request());
            if (idle_on) begin
                if (burst_left == 0) begin
                    hold_off($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end
            if ($urandom_range(0, 39) == 0) drain();
        end
    endtask

    initial begin
        logic [31:0] base;
        int unsigned failures;

        // drive every input to a known value before the first edge
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_THR_ONE;
        i_cfg_wdata      = '0;
        i_mode           = MODE_WRITE;
        i_way_index      = '0;
        i_byte_offset    = '0;
        i_now_tick       = '0;
        i_request_type   = '0;
        i_query_subblock = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases under reset thresholds.
        directed(MODE_HEAT,   3'd0, 6'd0,  32'd0,          16'h0000, 2'd0); // slot never written
        directed(MODE_VICTIM, 3'd0, 6'd0,  32'd0,          16'h0000, 2'd0); // every way qualifies
        directed(MODE_WRITE,  3'd0, 6'd0,  32'd5,          16'hFFFF, 2'd3);
        directed(MODE_WRITE,  3'd0, 6'd63, 32'hFFFF_FFFF,  16'h0000, 2'd0); // largest gap
        directed(MODE_WRITE,  3'd0, 6'd63, 32'd3,          16'h0000, 2'd0); // gap wraps to 4
        hold_off(3);
        directed(MODE_WRITE,  3'd7, 6'd16, 32'd50000,      16'h0000, 2'd1);
        directed(MODE_WRITE,  3'd7, 6'd16, 32'd100,        16'h0000, 2'd1); // time going back
        // walk one slot across each bin, landing exactly on the boundaries
        directed(MODE_WRITE,  3'd3, 6'd32, 32'd10000,      16'h0000, 2'd2);
        directed(MODE_WRITE,  3'd3, 6'd47, 32'd30000,      16'h0000, 2'd2);
        hold_off(1);
        directed(MODE_WRITE,  3'd3, 6'd40, 32'd60000,      16'h0000, 2'd2);
        directed(MODE_WRITE,  3'd3, 6'd33, 32'd100000,     16'h0000, 2'd2);
        directed(MODE_WRITE,  3'd3, 6'd32, 32'd140001,     16'h0000, 2'd2);
        directed(MODE_HEAT,   3'd3, 6'd0,  32'd0,          16'h0000, 2'd2);
        directed(MODE_HEAT,   3'd0, 6'd63, 32'hFFFF_FFFF,  16'h0000, 2'd3);
        hold_off(7);
        directed(MODE_HEAT,   3'd7, 6'd0,  32'd0,          16'h0000, 2'd1);
        directed(MODE_HEAT,   3'd5, 6'd0,  32'd0,          16'hFFFF, 2'd0);
        directed(MODE_VICTIM, 3'd2, 6'd0,  32'd0,          16'hFFFF, 2'd0);
        directed(MODE_VICTIM, 3'd0, 6'd0,  32'd0,          16'h1111, 2'd0);
        directed(MODE_VICTIM, 3'd0, 6'd0,  32'd0,          16'h0010, 2'd0);
        directed(MODE_VICTIM, 3'd7, 6'd63, 32'hFFFF_FFFF,  16'hEEEE, 2'd3);
        directed(MODE_UNUSED, 3'd3, 6'd32, 32'd777,        16'h0000, 2'd2);
        directed(MODE_UNUSED, 3'd6, 6'd63, 32'hFFFF_FFFF,  16'hFFFF, 2'd3);
        directed(MODE_WRITE,  3'd6, 6'd31, 32'd0,          16'h0000, 2'd0); // zero gap
        drain();

        // all thresholds zero: only a zero gap stays hottest
        tick_span = 32'd3;
        set_thresholds('0, '0, '0, '0);
        run_phase(PHASE_ITEMS, 1'b1);
        drain();

        // all thresholds at maximum; back-to-back with no idle gaps, though a drain may occur
        tick_span = 32'd1 << 20;
        set_thresholds('1, '1, '1, '1);
        run_phase(PHASE_ITEMS, 1'b0);
        drain();

        // unordered thresholds, plus a write to an unmapped index that must be ignored
        tick_span = 32'd2000;
        set_thresholds(32'd50000, 32'd10, 32'hFFFF_FFFF, 32'd0);
        write_reg(3'(int'(CFG_THR_FOUR) + $urandom_range(1, 4)), $urandom);
        run_phase(PHASE_ITEMS, 1'b1);
        drain();

        // small ordered thresholds with a time step that straddles them
        base = $urandom_range(1, 3000);
        tick_span = 32'd200;
        set_thresholds(base, base + $urandom_range(0, 3000), base + $urandom_range(3000, 6000),
                       base + $urandom_range(6000, 9000));
        run_phase(PHASE_ITEMS, 1'b1);
        drain();

        // arbitrary thresholds and step size
        tick_span = 32'd1 << $urandom_range(4, 28);
        set_thresholds($urandom, $urandom, $urandom, $urandom);
        run_phase(PHASE_ITEMS, 1'b1);
        drain();

        // reset values again, with every way open to writes
        open_ways = WAYS;
        tick_span = 32'd1000;
        set_thresholds(THR_ONE_RST, THR_TWO_RST, THR_THREE_RST, THR_FOUR_RST);
        run_phase(PHASE_ITEMS, 1'b1);

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (board.outstanding() != 0)
            $error("%0d predicted results never arrived", board.outstanding());
        failures = board.mismatches + board.outstanding();

        $display("Covered %0d touches, %0d victim picks, %0d heat reads, %0d unused-code ops",
                 board.mode_seen[MODE_WRITE], board.mode_seen[MODE_VICTIM],
                 board.mode_seen[MODE_HEAT], board.mode_seen[MODE_UNUSED]);
        $display("across %0d threshold settings in %0d cycles, %0d failures",
                 settings_run + 1, cycle_count, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
